FILE: hdl/mlpt_pkg.sv
package mlpt_pkg;

  localparam int ADDR_W         = 32;
  localparam int FRAME_W        = 32;
  localparam int MAX_LEVELS     = 4;
  localparam int MAX_LEVEL_BITS = 8;
  localparam int LVL_W          = 2;
  localparam int LCNT_W         = 3;
  localparam int BITS_W         = 4;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 4;
  localparam int SUM_W          = 6;

  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_COUNT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_BITS_0 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_BITS_1 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_BITS_2 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_BITS_3 = 3'd4;

  localparam logic FUNC_LOOKUP = 1'b0;
  localparam logic FUNC_INSERT = 1'b1;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef struct packed {
    logic               func;
    logic [ADDR_W-1:0]  logical_address;
    logic [FRAME_W-1:0] frame_number;
  } mlpt_in_t;

  typedef struct packed {
    logic               hit;
    logic [FRAME_W-1:0] found_frame;
    logic [ADDR_W-1:0]  found_address;
    logic               status;
  } mlpt_out_t;

  typedef struct packed {
    logic                                           func;
    logic [ADDR_W-1:0]                              addr;
    logic [FRAME_W-1:0]                             frame;
    logic [LCNT_W-1:0]                              levels;
    logic [MAX_LEVELS-1:0][MAX_LEVEL_BITS-1:0]      idx;
  } mlpt_cmd_t;

endpackage

FILE: hdl/multilevel_page_table.sv
// Channel  | Direction | Handshake              | Payload
// in_      | input     | in_valid / in_ready    | in_data  (func, logical_address, frame_number)
// out_     | output    | out_valid / out_ready  | out_data (hit, found_frame, found_address, status)
// cfg_     | input     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// A request passes from the queue to the walker; each level walked takes a link read, then a
// check. The walker then decides, writes each allocated link on an insert, reads the leaf on
// a lookup hit, and hands over the result.
// After reset a clearing pass writes every link to null, one a cycle; no request is taken
// meanwhile, while configuration writes are always accepted.
// A two-entry queue lets requests be taken while the walker is busy or a result waits.
module multilevel_page_table #(
  parameter int NODE_POOL = 64,
  parameter int LEAF_POOL = 256
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  mlpt_pkg::mlpt_in_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output mlpt_pkg::mlpt_out_t  out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [2:0]           cfg_index,
  input  logic [3:0]           cfg_data
);
  import mlpt_pkg::*;

  // The front clamps the geometry and cuts the address into per-level indices.
  mlpt_cmd_t push_cmd, pop_cmd;
  logic      push_valid, push_ready, pop_valid, pop_ready, busy_clear;

  mlpt_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .busy_clear (busy_clear),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  mlpt_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  // The back walks the link memory, allocates nodes and leaves, and holds the result.
  mlpt_back #(
    .NODE_POOL (NODE_POOL),
    .LEAF_POOL (LEAF_POOL)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (pop_valid),
    .cmd_ready  (pop_ready),
    .cmd        (pop_cmd),
    .busy_clear (busy_clear),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

FILE: hdl/mlpt_front.sv
module mlpt_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  mlpt_pkg::mlpt_in_t         in_data,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [2:0]                 cfg_index,
  input  logic [3:0]                 cfg_data,
  input  logic                       busy_clear,
  output logic                       push_valid,
  input  logic                       push_ready,
  output mlpt_pkg::mlpt_cmd_t        push_cmd
);
  import mlpt_pkg::*;

  logic [LCNT_W-1:0]                   level_count_r;
  logic [MAX_LEVELS-1:0][BITS_W-1:0]   level_bits_r;
  logic [MAX_LEVELS-1:0][BITS_W-1:0]   eff_bits;
  logic [MAX_LEVELS-1:0][SUM_W-1:0]    consumed;
  logic [LCNT_W-1:0]                   eff_levels;
  logic [2*ADDR_W-1:0]                 shifted [MAX_LEVELS];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_count_r <= LCNT_W'(1);
      for (int i = 0; i < MAX_LEVELS; i++) level_bits_r[i] <= BITS_W'(MAX_LEVEL_BITS);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_LEVEL_COUNT:  level_count_r   <= cfg_data[LCNT_W-1:0];
        REG_LEVEL_BITS_0: level_bits_r[0] <= cfg_data;
        REG_LEVEL_BITS_1: level_bits_r[1] <= cfg_data;
        REG_LEVEL_BITS_2: level_bits_r[2] <= cfg_data;
        REG_LEVEL_BITS_3: level_bits_r[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (level_count_r == '0) eff_levels = LCNT_W'(1);
    else if (level_count_r > LCNT_W'(MAX_LEVELS)) eff_levels = LCNT_W'(MAX_LEVELS);
    else eff_levels = level_count_r;
    for (int i = 0; i < MAX_LEVELS; i++) begin
      if (level_bits_r[i] == '0) eff_bits[i] = BITS_W'(1);
      else if (level_bits_r[i] > BITS_W'(MAX_LEVEL_BITS)) eff_bits[i] = BITS_W'(MAX_LEVEL_BITS);
      else eff_bits[i] = level_bits_r[i];
    end
    consumed[0] = '0;
    for (int i = 1; i < MAX_LEVELS; i++) consumed[i] = consumed[i-1] + SUM_W'(eff_bits[i-1]);
  end

  // Each level's field is brought to the top of the word; bits past the bottom shift in as zero.
  always_comb begin
    push_cmd.func   = in_data.func;
    push_cmd.addr   = in_data.logical_address;
    push_cmd.frame  = in_data.frame_number;
    push_cmd.levels = eff_levels;
    for (int i = 0; i < MAX_LEVELS; i++) begin
      shifted[i] = {{ADDR_W{1'b0}}, in_data.logical_address} << consumed[i];
      push_cmd.idx[i] = shifted[i][ADDR_W-1 -: MAX_LEVEL_BITS]
                        >> (BITS_W'(MAX_LEVEL_BITS) - eff_bits[i]);
    end
  end

  assign in_ready   = push_ready && !busy_clear;
  assign push_valid = in_valid && !busy_clear;

endmodule

FILE: hdl/mlpt_queue.sv
module mlpt_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push_valid,
  output logic                 push_ready,
  input  mlpt_pkg::mlpt_cmd_t  push_cmd,
  output logic                 pop_valid,
  input  logic                 pop_ready,
  output mlpt_pkg::mlpt_cmd_t  pop_cmd
);
  import mlpt_pkg::*;

  mlpt_cmd_t   slot_r [2];
  logic        wr_ptr_r, rd_ptr_r;
  logic [1:0]  count_r;
  logic        do_push, do_pop;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign pop_cmd    = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) slot_r[wr_ptr_r] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_push) wr_ptr_r <= !wr_ptr_r;
      if (do_pop)  rd_ptr_r <= !rd_ptr_r;
      count_r <= count_r + 2'(do_push) - 2'(do_pop);
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    count_r == 2'd2 |=> count_r != 2'd0) else $error("queue drained at once from full");
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != 2'd3) else $error("queue count out of range");
  a_pop_order: assert property (@(posedge clk) disable iff (!rst_n)
    do_pop |=> rd_ptr_r != $past(rd_ptr_r)) else $error("read pointer did not advance");
`endif

endmodule

FILE: hdl/mlpt_back.sv
module mlpt_back #(
  parameter int NODE_POOL = 64,
  parameter int LEAF_POOL = 256
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cmd_valid,
  output logic                 cmd_ready,
  input  mlpt_pkg::mlpt_cmd_t  cmd,
  output logic                 busy_clear,
  output logic                 out_valid,
  input  logic                 out_ready,
  output mlpt_pkg::mlpt_out_t  out_data
);
  import mlpt_pkg::*;

  localparam int MAXP    = (NODE_POOL > LEAF_POOL) ? NODE_POOL : LEAF_POOL;
  localparam int LINK_W  = $clog2(MAXP + 1);
  localparam int NODE_W  = (NODE_POOL > 1) ? $clog2(NODE_POOL) : 1;
  localparam int LEAF_W  = (LEAF_POOL > 1) ? $clog2(LEAF_POOL) : 1;
  localparam int NCNT_W  = $clog2(NODE_POOL + 1);
  localparam int LCNT2_W = $clog2(LEAF_POOL + 1);
  localparam int MEM_AW  = NODE_W + MAX_LEVEL_BITS;
  localparam int DEPTH   = NODE_POOL * (1 << MAX_LEVEL_BITS);

  typedef enum logic [7:0] {
    S_CLR   = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_WALK  = 8'b0000_0100,
    S_CHK   = 8'b0000_1000,
    S_EXEC  = 8'b0001_0000,
    S_ALLOC = 8'b0010_0000,
    S_LEAF  = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_t;

  logic [LINK_W-1:0]  links_mem  [DEPTH];
  logic [FRAME_W-1:0] frames_mem [LEAF_POOL];
  logic [ADDR_W-1:0]  addrs_mem  [LEAF_POOL];

  state_t             state_r, state_nxt;
  mlpt_cmd_t          cmd_r, cmd_nxt;
  logic [NODE_W-1:0]  node_r, node_nxt;
  logic [LVL_W-1:0]   d_r, d_nxt;
  logic [LEAF_W-1:0]  leaf_r, leaf_nxt;
  logic               found_r, found_nxt;
  logic [NCNT_W-1:0]  nodes_r, nodes_nxt;
  logic [LCNT2_W-1:0] leaves_r, leaves_nxt;
  logic [MEM_AW:0]    clr_r, clr_nxt;
  mlpt_out_t          res_r, res_nxt;
  mlpt_out_t          out_r, out_nxt;
  logic               out_valid_r, out_valid_nxt;

  logic [LINK_W-1:0]  rdata_r;
  logic [FRAME_W-1:0] lf_q;
  logic [ADDR_W-1:0]  la_q;
  logic [MEM_AW-1:0]  slot;
  logic               last;
  logic [LCNT_W-1:0]  need;
  logic               full;
  logic               mem_we;
  logic [MEM_AW-1:0]  mem_waddr;
  logic [LINK_W-1:0]  mem_wdata;
  logic               leaf_we;
  logic [LEAF_W-1:0]  leaf_waddr;

  assign slot = {node_r, cmd_r.idx[d_r]};
  assign last = (LCNT_W'(d_r) == cmd_r.levels - LCNT_W'(1));
  assign need = cmd_r.levels - LCNT_W'(1) - LCNT_W'(d_r);
  assign full = (32'(nodes_r) + 32'(need) > 32'(NODE_POOL)) ||
                (32'(leaves_r) >= 32'(LEAF_POOL));

  always_ff @(posedge clk) begin
    if (mem_we) links_mem[mem_waddr] <= mem_wdata;
    rdata_r <= links_mem[slot];
  end

  always_ff @(posedge clk) begin
    if (leaf_we) begin
      frames_mem[leaf_waddr] <= cmd_r.frame;
      addrs_mem[leaf_waddr]  <= cmd_r.addr;
    end
    lf_q <= frames_mem[leaf_r];
    la_q <= addrs_mem[leaf_r];
  end

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    node_nxt      = node_r;
    d_nxt         = d_r;
    leaf_nxt      = leaf_r;
    found_nxt     = found_r;
    nodes_nxt     = nodes_r;
    leaves_nxt    = leaves_r;
    clr_nxt       = clr_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd_ready     = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = slot;
    mem_wdata     = '0;
    leaf_we       = 1'b0;
    leaf_waddr    = leaf_r;
    case (state_r)
      S_CLR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r[MEM_AW-1:0];
        clr_nxt   = clr_r + 1'b1;
        if (32'(clr_r) == DEPTH - 1) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          cmd_nxt   = cmd;
          node_nxt  = '0;
          d_nxt     = '0;
          found_nxt = 1'b0;
          state_nxt = S_WALK;
        end
      end
      S_WALK: state_nxt = S_CHK;
      S_CHK: begin
        if (last) begin
          found_nxt = (rdata_r != '0) && (32'(rdata_r) <= 32'(leaves_r));
          leaf_nxt  = LEAF_W'(rdata_r - LINK_W'(1));
          state_nxt = S_EXEC;
        end else if ((rdata_r == '0) || (32'(rdata_r) > 32'(nodes_r))) begin
          state_nxt = S_EXEC;
        end else begin
          node_nxt  = NODE_W'(rdata_r - LINK_W'(1));
          d_nxt     = d_r + 1'b1;
          state_nxt = S_WALK;
        end
      end
      S_EXEC: begin
        res_nxt = '0;
        if (cmd_r.func == FUNC_LOOKUP) begin
          state_nxt = found_r ? S_LEAF : S_DONE;
        end else if (found_r) begin
          leaf_we   = 1'b1;
          state_nxt = S_DONE;
        end else if (full) begin
          res_nxt.status = STATUS_FULL;
          state_nxt      = S_DONE;
        end else begin
          state_nxt = S_ALLOC;
        end
      end
      S_ALLOC: begin
        mem_we = 1'b1;
        if (!last) begin
          mem_wdata = LINK_W'(nodes_r) + LINK_W'(1);
          node_nxt  = NODE_W'(nodes_r);
          nodes_nxt = nodes_r + 1'b1;
          d_nxt     = d_r + 1'b1;
        end else begin
          mem_wdata  = LINK_W'(leaves_r) + LINK_W'(1);
          leaf_we    = 1'b1;
          leaf_waddr = LEAF_W'(leaves_r);
          leaves_nxt = leaves_r + 1'b1;
          state_nxt  = S_DONE;
        end
      end
      S_LEAF: begin
        res_nxt.hit           = 1'b1;
        res_nxt.found_frame   = lf_q;
        res_nxt.found_address = la_q;
        res_nxt.status        = STATUS_OK;
        state_nxt             = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      nodes_r     <= NCNT_W'(1);
      leaves_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      nodes_r     <= nodes_nxt;
      leaves_r    <= leaves_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r   <= cmd_nxt;
    node_r  <= node_nxt;
    d_r     <= d_nxt;
    leaf_r  <= leaf_nxt;
    found_r <= found_nxt;
    res_r   <= res_nxt;
    out_r   <= out_nxt;
  end

  assign busy_clear = (state_r == S_CLR);
  assign out_valid  = out_valid_r;
  assign out_data   = out_r;

`ifndef ASSERT_OFF
  a_nodes_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(nodes_r) <= 32'(NODE_POOL)) else $error("node pool overrun");
  a_leaves_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(leaves_r) <= 32'(LEAF_POOL)) else $error("leaf pool overrun");
  a_no_take_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CLR |-> !cmd_ready) else $error("request taken during clearing pass");
  a_alloc_only_insert: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_ALLOC |-> cmd_r.func == FUNC_INSERT) else $error("lookup allocated");
`endif

endmodule
